FILE: sv/ttcb_pkg.sv
// Package with the shared constants and control structs of the trace capture buffer.
`timescale 1ns / 1ps

package ttcb_pkg;

    // Default geometry of the trace ring.
    localparam int TRACE_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 64;

    // Fixed field widths of the transactions.
    localparam int WORD_W   = 64;
    localparam int REASON_W = 8;
    localparam int LEVEL_W  = 8;
    localparam int DELAY_W  = 11;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 16;

    // Request codes.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_FLAG   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Longest trigger delay in ticks, and the disarmed marker.
    localparam logic signed [DELAY_W-1:0] DELAY_MAX = 11'sd900;
    localparam logic signed [DELAY_W-1:0] DELAY_OFF = -11'sd1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_OFF = -8'sd1;

    // Command from the sequencer to the trigger unit.
    typedef struct packed {
        logic                       flag;
        logic                       tick;
        logic [REASON_W-1:0]        reason;
        logic signed [LEVEL_W-1:0]  level;
        logic signed [DELAY_W-1:0]  delay;
    } t_trig_cmd;

    // Status of the trigger unit seen by the sequencer.
    typedef struct packed {
        logic                       expire;
        logic [REASON_W-1:0]        reason;
        logic [COUNT_W-1:0]         count;
    } t_trig_stat;

endpackage

FILE: sv/ttcb_req_if.sv
// Interface of the request channel.
`timescale 1ns / 1ps

interface ttcb_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              req_type;
    logic [ttcb_pkg::WORD_W-1:0]             sample_word;
    logic [ttcb_pkg::REASON_W-1:0]           reason_code;
    logic signed [ttcb_pkg::LEVEL_W-1:0]     trigger_level;
    logic signed [ttcb_pkg::DELAY_W-1:0]     trigger_delay;

    modport source (output valid, req_type, sample_word, reason_code, trigger_level,
                    trigger_delay, input ready);
    modport sink (input valid, req_type, sample_word, reason_code, trigger_level,
                  trigger_delay, output ready);
endinterface

FILE: sv/ttcb_dump_if.sv
// Interface of the dump result channel.
`timescale 1ns / 1ps

interface ttcb_dump_if;
    logic                              valid;
    logic                              ready;
    logic [ttcb_pkg::WORD_W-1:0]       dump_word;
    logic [ttcb_pkg::REASON_W-1:0]     dump_reason;
    logic [ttcb_pkg::POS_W-1:0]        dump_position;
    logic                              dump_last;
    logic                              dump_empty;
    logic [ttcb_pkg::COUNT_W-1:0]      dumps_so_far;

    modport source (output valid, dump_word, dump_reason, dump_position, dump_last,
                    dump_empty, dumps_so_far, input ready);
    modport sink (input valid, dump_word, dump_reason, dump_position, dump_last,
                  dump_empty, dumps_so_far, output ready);
endinterface

FILE: sv/ttcb_ring.sv
// Trace ring: sample memory with newest pointer, fill count and oldest-first read.
`timescale 1ns / 1ps

module ttcb_ring #(
    parameter int DEPTH = ttcb_pkg::TRACE_DEPTH_DEF,
    parameter int WIDTH = ttcb_pkg::SAMPLE_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_idx,
    output logic [WIDTH-1:0] o_rd_data,
    output logic [CW-1:0]    o_fill
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic [AW-1:0]    r_newest, n_newest;
    logic [CW-1:0]    r_fill, n_fill;
    logic             full;
    logic [AW-1:0]    after_newest;
    logic [AW-1:0]    start;
    logic [AW:0]      sum;
    logic [AW-1:0]    rd_addr;

    assign full         = (r_fill == CW'(DEPTH));
    assign after_newest = (r_newest == AW'(DEPTH - 1)) ? '0 : r_newest + AW'(1);

    // The oldest entry sits after the newest once the ring has wrapped, else at zero.
    assign start   = full ? after_newest : '0;
    assign sum     = {1'b0, start} + {1'b0, i_rd_idx};
    assign rd_addr = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : sum[AW-1:0];

    // Write slot follows the fill count until full, then overwrites the oldest.
    always_comb begin
        n_newest = r_newest;
        n_fill   = r_fill;
        if (i_wr_en) begin
            if (full) begin
                n_newest = after_newest;
            end else begin
                n_newest = r_fill[AW-1:0];
                n_fill   = r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_fill   <= '0;
        end else begin
            r_newest <= n_newest;
            r_fill   <= n_fill;
        end
    end

    // Sample memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[n_newest] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;

endmodule

FILE: sv/ttcb_trigger.sv
// Trigger unit: delay clamp, level priority, tick countdown and dump counter.
`timescale 1ns / 1ps

module ttcb_trigger (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttcb_pkg::t_trig_cmd i_cmd,
    output ttcb_pkg::t_trig_stat o_stat
);

    logic signed [ttcb_pkg::DELAY_W-1:0] r_delay, n_delay;
    logic signed [ttcb_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [ttcb_pkg::REASON_W-1:0]       r_reason, n_reason;
    logic [ttcb_pkg::COUNT_W-1:0]        r_count, n_count;
    logic signed [ttcb_pkg::DELAY_W-1:0] clamped;
    logic                                armed;
    logic                                expire;

    // Flag delays are held to the range zero to the maximum.
    always_comb begin
        if (i_cmd.delay < 0) begin
            clamped = '0;
        end else if (i_cmd.delay > ttcb_pkg::DELAY_MAX) begin
            clamped = ttcb_pkg::DELAY_MAX;
        end else begin
            clamped = i_cmd.delay;
        end
    end

    assign armed  = !r_delay[ttcb_pkg::DELAY_W-1];
    assign expire = i_cmd.tick && armed && (r_delay == '0);

    // A tick counts down; the tick that passes zero disarms and bumps the counter.
    always_comb begin
        n_delay  = r_delay;
        n_level  = r_level;
        n_reason = r_reason;
        n_count  = r_count;
        if (i_cmd.tick && armed) begin
            if (expire) begin
                n_delay = ttcb_pkg::DELAY_OFF;
                n_level = ttcb_pkg::LEVEL_OFF;
                n_count = r_count + ttcb_pkg::COUNT_W'(1);
            end else begin
                n_delay = r_delay - ttcb_pkg::DELAY_W'(1);
            end
        end else if (i_cmd.flag && (i_cmd.level > r_level)) begin
            n_delay  = clamped;
            n_level  = i_cmd.level;
            n_reason = i_cmd.reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= ttcb_pkg::DELAY_OFF;
            r_level  <= ttcb_pkg::LEVEL_OFF;
            r_reason <= '0;
            r_count  <= '0;
        end else begin
            r_delay  <= n_delay;
            r_level  <= n_level;
            r_reason <= n_reason;
            r_count  <= n_count;
        end
    end

    assign o_stat.expire = expire;
    assign o_stat.reason = r_reason;
    assign o_stat.count  = r_count;

endmodule

FILE: sv/triggered_trace_capture_buffer.sv
// Top level of the triggered trace capture buffer with its dump sequencer.
//
// Usage: requests arrive on i_req (valid/ready). A sample transaction stores a
// word in a ring of TRACE_DEPTH entries, overwriting the oldest once full. A flag
// transaction arms a trigger whose delay is clamped to 0..900 ticks; it replaces
// a pending trigger only when its level is strictly higher. A tick transaction
// counts the delay down; the tick that expires it starts a dump on o_dump.
// Sample, flag, tick and unknown requests finish when accepted, so one such
// transaction is accepted per clock while the block is idle.
// A dump delivers one transaction per filled entry, oldest first, with
// dump_last on the final one, or one transaction marked empty when the ring is
// empty. Each dump result passes through a memory read, an output load and
// a hand over in turn, and the next entry is read only after the previous
// result is handed over. An empty dump skips the read, so its only result
// is offered straight after the load that follows the expiring tick.
// i_req.ready is low for the whole dump. When the receiver stalls, the result
// is held in the output register and the walk waits.
// Reset clears the ring pointers, disarms the trigger and zeroes the dump
// counter; the sample memory itself is not cleared.
`timescale 1ns / 1ps

module triggered_trace_capture_buffer #(
    parameter int TRACE_DEPTH = ttcb_pkg::TRACE_DEPTH_DEF,
    parameter int SAMPLE_BITS = ttcb_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttcb_req_if.sink    i_req,
    ttcb_dump_if.source o_dump
);

    localparam int AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int CW = $clog2(TRACE_DEPTH + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [AW-1:0]                  r_idx, n_idx;
    logic                           r_empty, n_empty;
    logic                           r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]         r_word;
    logic [ttcb_pkg::REASON_W-1:0]  r_reason;
    logic [AW-1:0]                  r_pos;
    logic                           r_last;
    logic                           r_out_empty;
    logic [ttcb_pkg::COUNT_W-1:0]   r_count;

    logic                           accept;
    logic                           wr_en;
    logic                           rd_en;
    logic [SAMPLE_BITS-1:0]         rd_data;
    logic [CW-1:0]                  fill;
    logic                           at_last;
    ttcb_pkg::t_trig_cmd            trig_cmd;
    ttcb_pkg::t_trig_stat           trig_stat;

    assign accept = i_req.valid && i_req.ready;
    assign wr_en  = accept && (i_req.req_type == ttcb_pkg::REQ_SAMPLE);
    assign rd_en  = (r_state == S_READ);

    // Request decode into the trigger unit.
    assign trig_cmd.flag   = accept && (i_req.req_type == ttcb_pkg::REQ_FLAG);
    assign trig_cmd.tick   = accept && (i_req.req_type == ttcb_pkg::REQ_TICK);
    assign trig_cmd.reason = i_req.reason_code;
    assign trig_cmd.level  = i_req.trigger_level;
    assign trig_cmd.delay  = i_req.trigger_delay;

    ttcb_ring #(
        .DEPTH (TRACE_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (i_req.sample_word[SAMPLE_BITS-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_idx),
        .o_rd_data (rd_data),
        .o_fill    (fill)
    );

    ttcb_trigger u_trigger (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (trig_cmd),
        .o_stat  (trig_stat)
    );

    assign at_last = r_empty || (CW'(r_idx) == fill - CW'(1));

    // Dump sequencer: read one entry, load it into the output register, hand it over.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (trig_stat.expire) begin
                    n_idx   = '0;
                    n_empty = (fill == '0);
                    n_state = (fill == '0) ? S_LOAD : S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (o_dump.ready) begin
                    n_out_valid = 1'b0;
                    if (at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register, loaded once per dump result.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_word      <= r_empty ? '0 : rd_data;
            r_reason    <= trig_stat.reason;
            r_pos       <= r_idx;
            r_last      <= at_last;
            r_out_empty <= r_empty;
            r_count     <= trig_stat.count;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_dump.valid         = r_out_valid;
    assign o_dump.dump_word     = ttcb_pkg::WORD_W'(r_word);
    assign o_dump.dump_reason   = r_reason;
    assign o_dump.dump_position = ttcb_pkg::POS_W'(r_pos);
    assign o_dump.dump_last     = r_last;
    assign o_dump.dump_empty    = r_out_empty;
    assign o_dump.dumps_so_far  = r_count;

`ifndef SYNTH
    // No request is taken while a dump result waits.
    a_no_req_during_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dump.valid |-> !i_req.ready)
        else $error("request channel ready while a dump result is pending");

    // The final dump transaction returns the sequencer to idle.
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dump.valid && o_dump.ready && o_dump.dump_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the last result");

    // An empty dump is always a single, final transaction.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dump.valid && o_dump.dump_empty) |-> o_dump.dump_last)
        else $error("empty dump result not marked last");

    // The walk never reaches beyond the filled entries.
    a_idx_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && !r_empty) |-> (CW'(r_idx) < fill))
        else $error("dump index beyond the fill count");
`endif

endmodule
